// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bmprle_pkg.sv =====
// Shared types and constants of the BMP RLE decoder
`timescale 1ns / 1ps

package bmprle_pkg;

  localparam int MAX_HEIGHT_DEF  = 4096;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NIBBLE_MODE  = 2'd2;

  // escape commands following a zero count
  localparam logic [7:0] CMD_EOL   = 8'd0;
  localparam logic [7:0] CMD_EOB   = 8'd1;
  localparam logic [7:0] CMD_DELTA = 8'd2;

  localparam logic [15:0] COL_MAX = 16'hFFFF;
  localparam logic [12:0] ROW_MAX = 13'h1FFF;

  typedef struct packed {
    logic [12:0] image_height;
    logic        flip_rows;
    logic        nibble_mode;
  } cfg_t;

  // one queued write descriptor, row still unflipped
  typedef struct packed {
    logic        is_end;
    logic [12:0] row;
    logic [15:0] col;
    logic [7:0]  count;
    logic [7:0]  value;
  } wr_desc_t;

endpackage

// ===== rtl/bmprle_fifo.sv =====
// Short descriptor queue between parser and writer
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmprle_fifo
  import bmprle_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  wr_desc_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output wr_desc_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wr_desc_t          slot_r [DEPTH];
  logic [AW-1:0]     wptr_r, wptr_nxt;
  logic [AW-1:0]     rptr_r, rptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = slot_r[rptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  `ASSERT_CLK(a_cnt_bound, clk, rst_n, cnt_r <= CW'(DEPTH), "queue count beyond depth")
  `ASSERT_CLK(a_no_overrun, clk, rst_n, push |-> !full, "push into full queue")

endmodule

// ===== rtl/bmprle_parser.sv =====
// Front end: byte parser, row/column tracking, descriptor generation
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmprle_parser
  import bmprle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     beat,
  input  logic [7:0] data_byte,
  output logic     push,
  output wr_desc_t push_data
);

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_CMD,
    PH_DX,
    PH_DY,
    PH_ABS,
    PH_PAD
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  abs_left_r, abs_left_nxt;
  logic        pad_r, pad_nxt;
  logic [12:0] row_r, row_nxt;
  logic [15:0] col_r, col_nxt;
  logic        fin_r, fin_nxt;
  logic [7:0]  abs_n;

  function automatic logic [15:0] sat_col(input logic [15:0] c, input logic [7:0] d);
    logic [16:0] s;
    s = {1'b0, c} + {9'b0, d};
    return s[16] ? COL_MAX : s[15:0];
  endfunction

  function automatic logic [12:0] sat_row(input logic [12:0] r, input logic [7:0] d);
    logic [13:0] s;
    s = {1'b0, r} + {6'b0, d};
    return s[13] ? ROW_MAX : s[12:0];
  endfunction

  // pixels taken by one absolute data byte
  always_comb begin
    abs_n = (cfg.nibble_mode && (abs_left_r >= 8'd2)) ? 8'd2 : 8'd1;
    if (abs_n > abs_left_r) begin
      abs_n = abs_left_r;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    abs_left_nxt = abs_left_r;
    pad_nxt      = pad_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    fin_nxt      = fin_r;
    push         = 1'b0;
    push_data    = '0;
    if (beat && !fin_r) begin
      unique case (phase_r)
        PH_COUNT: begin
          held_nxt  = data_byte;
          phase_nxt = PH_CMD;
        end
        PH_CMD: begin
          phase_nxt = PH_COUNT;
          if (held_r != 8'd0) begin
            push            = 1'b1;
            push_data.row   = row_r;
            push_data.col   = col_r;
            push_data.count = held_r;
            push_data.value = data_byte;
            col_nxt         = sat_col(col_r, held_r);
          end else begin
            unique case (data_byte)
              CMD_EOL: begin
                row_nxt = sat_row(row_r, 8'd1);
                col_nxt = '0;
              end
              CMD_EOB: begin
                fin_nxt          = 1'b1;
                push             = 1'b1;
                push_data.is_end = 1'b1;
              end
              CMD_DELTA: begin
                phase_nxt = PH_DX;
              end
              default: begin
                abs_left_nxt = data_byte;
                // RLE4 pads when count mod 4 is 1 or 2
                pad_nxt      = cfg.nibble_mode ? (data_byte[1] ^ data_byte[0]) : data_byte[0];
                phase_nxt    = PH_ABS;
              end
            endcase
          end
        end
        PH_DX: begin
          col_nxt   = sat_col(col_r, data_byte);
          phase_nxt = PH_DY;
        end
        PH_DY: begin
          row_nxt   = sat_row(row_r, data_byte);
          phase_nxt = PH_COUNT;
        end
        PH_ABS: begin
          push            = 1'b1;
          push_data.row   = row_r;
          push_data.col   = col_r;
          push_data.count = abs_n;
          push_data.value = data_byte;
          col_nxt         = sat_col(col_r, abs_n);
          abs_left_nxt    = abs_left_r - abs_n;
          if (abs_left_nxt == 8'd0) begin
            phase_nxt = pad_r ? PH_PAD : PH_COUNT;
            pad_nxt   = 1'b0;
          end
        end
        PH_PAD: begin
          phase_nxt = PH_COUNT;
        end
        default: begin
          phase_nxt = PH_COUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_COUNT;
      held_r     <= '0;
      abs_left_r <= '0;
      pad_r      <= 1'b0;
      row_r      <= '0;
      col_r      <= '0;
      fin_r      <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      held_r     <= held_nxt;
      abs_left_r <= abs_left_nxt;
      pad_r      <= pad_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      fin_r      <= fin_nxt;
    end
  end

  `ASSERT_CLK(a_fin_sticky, clk, rst_n, fin_r |=> fin_r, "end of bitmap flag dropped")
  `ASSERT_CLK(a_abs_left, clk, rst_n, (phase_r == PH_ABS) |-> (abs_left_r != 8'd0),
              "absolute run with nothing left")
  `ASSERT_CLK(a_push_after_end, clk, rst_n, fin_r |-> !push, "descriptor after end of bitmap")

endmodule

// ===== rtl/bmprle_writer.sv =====
// Back end: row flip, overflow flag and registered output stage
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmprle_writer
  import bmprle_pkg::*;
#(
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       desc_valid,
  input  wr_desc_t   desc,
  output logic       desc_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [11:0] row_o,
  output logic [15:0] col_o,
  output logic [7:0]  count_o,
  output logic [7:0]  value_o,
  output logic        end_o,
  output logic        ovf_o
);

  localparam int HCW = ($clog2(MAX_HEIGHT + 1) > 13) ? $clog2(MAX_HEIGHT + 1) : 13;

  logic        valid_r;
  logic [11:0] row_r;
  logic [15:0] col_r;
  logic [7:0]  count_r;
  logic [7:0]  value_r;
  logic        end_r;
  logic        ovf_r;
  logic [12:0] h_eff;
  logic [12:0] flipped;
  logic        row_ovf;
  logic [11:0] row_sel;

  // clamp only matters when the limit is below what the register can hold
  assign h_eff   = (HCW'(cfg.image_height) > HCW'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT)
                                                                : cfg.image_height;
  assign row_ovf = !desc.is_end && (desc.row >= h_eff);
  assign flipped = h_eff - desc.row - 13'd1;
  assign row_sel = (desc.is_end || row_ovf) ? 12'd0
                 : (cfg.flip_rows ? flipped[11:0] : desc.row[11:0]);

  assign desc_pop = desc_valid && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (desc_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_pop) begin
      row_r   <= row_sel;
      col_r   <= desc.col;
      count_r <= desc.count;
      value_r <= desc.value;
      end_r   <= desc.is_end;
      ovf_r   <= row_ovf;
    end
  end

  assign out_valid = valid_r;
  assign row_o     = row_r;
  assign col_o     = col_r;
  assign count_o   = count_r;
  assign value_o   = value_r;
  assign end_o     = end_r;
  assign ovf_o     = ovf_r;

  `ASSERT_CLK(a_end_clean, clk, rst_n, (valid_r && end_r) |-> (!ovf_r && row_r == 12'd0),
              "end marker carries write fields")
  `ASSERT_CLK(a_ovf_row, clk, rst_n, (valid_r && ovf_r) |-> (row_r == 12'd0),
              "overflowed write with nonzero row")

endmodule

// ===== rtl/bmp_rle_decoder_core.sv =====
// Top level of the BMP RLE8/RLE4 pixel stream decoder
//
//  port group  dir  beat contents
//  in_*        in   tdata[7:0] data_byte
//  out_*       out  tdata row/col/count/value, tuser end_marker/row_overflow
//  cfg_*       in   register write: index, data, enable
//
//  One byte per cycle sustained while the queue is not full; the parser updates its state on each byte beat.
//  A descriptor is registered in the queue, then in the output register,
//  before its result beat appears on out_*.
//  The queue of QUEUE_DEPTH entries lets either side stall independently;
//  in_tready drops only when the queue is full.
//  Synchronous reset clears parser state, queue and registers; bytes after
//  end of bitmap are taken and dropped until reset.
`timescale 1ns / 1ps

module bmp_rle_decoder_core
  import bmprle_pkg::*;
#(
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [11:0] out_row, [27:12] out_col,
                                             // [35:28] pixel_count, [43:36] pixel_value
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [0] end_marker, [1] row_overflow
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t     cfg_r;
  logic     q_full;
  logic     q_push;
  wr_desc_t q_in;
  logic     q_not_empty;
  wr_desc_t q_out;
  logic     q_pop;
  logic [11:0] row_w;
  logic [15:0] col_w;
  logic [7:0]  count_w;
  logic [7:0]  value_w;
  logic        end_w;
  logic        ovf_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_height <= 13'd1;
      cfg_r.flip_rows    <= 1'b0;
      cfg_r.nibble_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_wdata;
        REG_FLIP_ROWS:    cfg_r.flip_rows    <= cfg_wdata[0];
        REG_NIBBLE_MODE:  cfg_r.nibble_mode  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign in_tready = !q_full;

  bmprle_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .beat      (in_tvalid && in_tready),
    .data_byte (in_tdata[7:0]),
    .push      (q_push),
    .push_data (q_in)
  );

  bmprle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  bmprle_writer #(
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_writer (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .desc_valid (q_not_empty),
    .desc       (q_out),
    .desc_pop   (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .row_o      (row_w),
    .col_o      (col_w),
    .count_o    (count_w),
    .value_o    (value_w),
    .end_o      (end_w),
    .ovf_o      (ovf_w)
  );

  assign out_tdata = {4'b0, value_w, count_w, col_w, row_w};
  assign out_tuser = {ovf_w, end_w};

endmodule
